>>> rtl/core/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// shared types, register indexes and reset values of the led blink generator
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int TIME_WIDTH_DEF = 32;

  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 32;
  localparam int COUNT_W  = 16;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF       = 3'd0,
    MODE_ON        = 3'd1,
    MODE_SLOW      = 3'd2,
    MODE_FAST      = 3'd3,
    MODE_BLINK_N   = 3'd4,
    MODE_HEARTBEAT = 3'd5
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ON_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_TIME  = 3'd6;

  localparam logic [PERIOD_W-1:0] SLOW_TOGGLE_RST       = 32'd1000;
  localparam logic [PERIOD_W-1:0] FAST_TOGGLE_RST       = 32'd200;
  localparam logic [PERIOD_W-1:0] HEARTBEAT_HALF_PERIOD = 32'd500;
  localparam logic [COUNT_W-1:0]  BLINK_GOAL_RST        = 16'd0;
  localparam logic [PERIOD_W-1:0] ON_PERIOD_RST         = 32'd100;
  localparam logic [PERIOD_W-1:0] DARK_TIME_RST         = 32'd100;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] slow_period;
    logic [PERIOD_W-1:0] fast_period;
    logic [PERIOD_W-1:0] heartbeat_half_period;
    logic [COUNT_W-1:0]  blink_count_goal;
    logic [PERIOD_W-1:0] on_period;
    logic [PERIOD_W-1:0] dark_time;
  } cfg_t;

endpackage

>>> rtl/core/lbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbp_cfg_regs
// configuration register file, flags a mode write for the state restart
// ----------------------------------------------------------------------------
module lbp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] wr_data,
  output lbp_pkg::cfg_t                  cfg,
  output logic                           mode_wr
);
  import lbp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MODE:       cfg_nxt.mode                  = wr_data[MODE_W-1:0];
        REG_SLOW:       cfg_nxt.slow_period           = wr_data[PERIOD_W-1:0];
        REG_FAST:       cfg_nxt.fast_period           = wr_data[PERIOD_W-1:0];
        REG_HEARTBEAT:  cfg_nxt.heartbeat_half_period = wr_data[PERIOD_W-1:0];
        REG_TARGET:     cfg_nxt.blink_count_goal      = wr_data[COUNT_W-1:0];
        REG_ON_PERIOD:  cfg_nxt.on_period             = wr_data[PERIOD_W-1:0];
        REG_DARK_TIME:  cfg_nxt.dark_time             = wr_data[PERIOD_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                  <= MODE_OFF;
      cfg_r.slow_period           <= SLOW_TOGGLE_RST;
      cfg_r.fast_period           <= FAST_TOGGLE_RST;
      cfg_r.heartbeat_half_period <= HEARTBEAT_HALF_PERIOD;
      cfg_r.blink_count_goal      <= BLINK_GOAL_RST;
      cfg_r.on_period             <= ON_PERIOD_RST;
      cfg_r.dark_time             <= DARK_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign mode_wr = wr_en && (wr_index == REG_MODE);

endmodule

>>> rtl/core/lbp_step_logic.sv
// ----------------------------------------------------------------------------
// lbp_step_logic
// next-state logic of one tick: elapsed time check and mode behavior
// ----------------------------------------------------------------------------
module lbp_step_logic #(
  parameter int TIME_WIDTH = lbp_pkg::TIME_WIDTH_DEF
) (
  input  lbp_pkg::cfg_t                 cfg,
  input  logic [TIME_WIDTH-1:0]         now,
  input  logic                          level,
  input  logic [TIME_WIDTH-1:0]         last_time,
  input  logic [lbp_pkg::COUNT_W-1:0]   counter,
  input  logic                          restart,
  output logic                          level_nxt,
  output logic [TIME_WIDTH-1:0]         last_time_nxt,
  output logic [lbp_pkg::COUNT_W-1:0]   counter_nxt,
  output logic                          changed
);
  import lbp_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

  logic [TIME_WIDTH-1:0] origin;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [PERIOD_W-1:0]   period;
  logic                  over;

  // a pending restart makes this tick the new origin
  assign origin  = restart ? now : last_time;
  assign elapsed = now - origin;

  always_comb begin
    case (cfg.mode)
      MODE_SLOW:      period = cfg.slow_period;
      MODE_FAST:      period = cfg.fast_period;
      MODE_HEARTBEAT: period = cfg.heartbeat_half_period;
      MODE_BLINK_N:   period = level ? cfg.on_period : cfg.dark_time;
      default:        period = cfg.slow_period;
    endcase
  end

  assign over = CMP_W'(elapsed) >= CMP_W'(period);

  always_comb begin
    level_nxt     = level;
    last_time_nxt = origin;
    counter_nxt   = counter;
    if (restart && (cfg.mode == MODE_BLINK_N) && (cfg.blink_count_goal != '0)) begin
      // first blink lights at once
      level_nxt   = 1'b1;
      counter_nxt = COUNT_W'(1);
    end else begin
      case (cfg.mode)
        MODE_ON: level_nxt = 1'b1;
        MODE_SLOW, MODE_FAST, MODE_HEARTBEAT: begin
          if (over) begin
            last_time_nxt = now;
            level_nxt     = ~level;
          end
        end
        MODE_BLINK_N: begin
          if (level) begin
            if (over) begin
              last_time_nxt = now;
              level_nxt     = 1'b0;
            end
          end else if (counter < cfg.blink_count_goal) begin
            if (over) begin
              last_time_nxt = now;
              level_nxt     = 1'b1;
              counter_nxt   = counter + COUNT_W'(1);
            end
          end
        end
        default: level_nxt = 1'b0;
      endcase
    end
  end

  assign changed = level_nxt != level;

endmodule

>>> rtl/core/led_blink_pattern_generator.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_generator
// single-led blink pattern generator driven by timestamp ticks
// ----------------------------------------------------------------------------
// path: out_valid rises once the tick transaction has passed the input register,
//   then the result register; throughput: one tick per cycle while out_ready is high,
//   set by the combinational subtract/compare between the tick register and the result register
// reset: synchronous active-low rst_n; led dark, origin and counter zero,
//   no restart pending, registers at their default values
// ----------------------------------------------------------------------------
module led_blink_pattern_generator #(
  parameter int TIME_WIDTH = lbp_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lbp_pkg::TICK_W-1:0]     in_tick_time,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_led_level,
  output logic                           out_level_changed
);
  import lbp_pkg::*;

  cfg_t cfg;
  logic mode_wr;

  // tick register
  logic                  tick_valid_r;
  logic [TIME_WIDTH-1:0] tick_time_r;

  // blink state
  logic                  level_r;
  logic [TIME_WIDTH-1:0] last_time_r;
  logic [COUNT_W-1:0]    counter_r;
  logic                  restart_r;

  logic                  level_nxt;
  logic [TIME_WIDTH-1:0] last_time_nxt;
  logic [COUNT_W-1:0]    counter_nxt;
  logic                  changed;

  // result register
  logic out_valid_r;
  logic out_level_r;
  logic out_changed_r;

  logic out_free;
  logic step;
  logic in_fire;

  lbp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .mode_wr  (mode_wr)
  );

  lbp_step_logic #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step_logic (
    .cfg           (cfg),
    .now           (tick_time_r),
    .level         (level_r),
    .last_time     (last_time_r),
    .counter       (counter_r),
    .restart       (restart_r),
    .level_nxt     (level_nxt),
    .last_time_nxt (last_time_nxt),
    .counter_nxt   (counter_nxt),
    .changed       (changed)
  );

  // result slot frees when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;
  // a held tick is evaluated once the result slot can take it
  assign step     = tick_valid_r && out_free;
  assign in_ready = !tick_valid_r || step;
  assign in_fire  = in_valid && in_ready;

  // tick register, timestamp cut or widened to the time width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_ready) begin
      tick_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_time_r <= TIME_WIDTH'(in_tick_time);
    end
  end

  // blink state; the user must write the mode only while no transaction is in flight (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      last_time_r <= '0;
      counter_r   <= '0;
      restart_r   <= 1'b0;
    end else if (mode_wr) begin
      level_r   <= 1'b0;
      counter_r <= '0;
      restart_r <= 1'b1;
    end else if (step) begin
      level_r     <= level_nxt;
      last_time_r <= last_time_nxt;
      counter_r   <= counter_nxt;
      restart_r   <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= tick_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_level_r   <= level_nxt;
      out_changed_r <= changed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_level     = out_level_r;
  assign out_level_changed = out_changed_r;

endmodule
